// ===== rtl/core/history_cursor_deque_assert.svh =====
// Assertion macros for the history cursor deque RTL.
`ifndef HISTORY_CURSOR_DEQUE_ASSERT_SVH
`define HISTORY_CURSOR_DEQUE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HCD_ASSERT_HOLDS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/hcd_pkg.sv =====
// Package with the shared types and constants of the history cursor deque.
`timescale 1ns / 1ps
`default_nettype none

package hcd_pkg;

  // Operation codes carried on the func field.
  localparam int FUNC_W = 3;
  localparam logic [FUNC_W-1:0] FUNC_ADD     = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_BACK    = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_FORWARD = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_TRUNC   = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_EXPIRE  = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_TRIM    = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_READ    = 3'd6;

  // Status codes reported with each result.
  localparam int STATUS_W = 2;
  localparam logic [STATUS_W-1:0] STATUS_KEPT    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_MOVED   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTIED = 2'd2;

  // Configuration register map.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;
  localparam logic [CFG_INDEX_W-1:0] CFG_LIMIT  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_EXPIRY = 2'd1;

  localparam int LIMIT_W  = 5;
  localparam int EXPIRY_W = 32;
  localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 5'd16;
  localparam logic [EXPIRY_W-1:0] EXPIRY_RESET = 32'd1000000;

  // Sequencer states, one-hot.
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EXEC = 6'b000010,
    S_SCAN = 6'b000100,
    S_DROP = 6'b001000,
    S_RD   = 6'b010000,
    S_RESP = 6'b100000
  } state_t;

  // Control strobes from the sequencer to the entry memories.
  typedef struct packed {
    logic wr_en;
    logic h_rd_en;
    logic s_rd_en;
  } store_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/hcd_store.sv =====
// Entry memories of the history cursor deque: handles and time stamps.
`timescale 1ns / 1ps
`default_nettype none

module hcd_store #(
  parameter int HISTORY_DEPTH = 16,
  parameter int HANDLE_BITS   = 16,
  parameter int TIME_BITS     = 32
) (
  input  wire logic                             clk,
  input  wire hcd_pkg::store_ctl_t              ctl,
  input  wire logic [$clog2(HISTORY_DEPTH)-1:0] wr_addr,
  input  wire logic [HANDLE_BITS-1:0]           wr_handle,
  input  wire logic [TIME_BITS-1:0]             wr_stamp,
  input  wire logic [$clog2(HISTORY_DEPTH)-1:0] h_rd_addr,
  input  wire logic [$clog2(HISTORY_DEPTH)-1:0] s_rd_addr,
  output logic      [HANDLE_BITS-1:0]           h_rd_data,
  output logic      [TIME_BITS-1:0]             s_rd_data
);

  logic [HANDLE_BITS-1:0] handle_mem [HISTORY_DEPTH];
  logic [TIME_BITS-1:0]   stamp_mem  [HISTORY_DEPTH];
  logic [HANDLE_BITS-1:0] h_rd_data_r;
  logic [TIME_BITS-1:0]   s_rd_data_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      handle_mem[wr_addr] <= wr_handle;
      stamp_mem[wr_addr]  <= wr_stamp;
    end
    if (ctl.h_rd_en) begin
      h_rd_data_r <= handle_mem[h_rd_addr];
    end
    if (ctl.s_rd_en) begin
      s_rd_data_r <= stamp_mem[s_rd_addr];
    end
  end

  assign h_rd_data = h_rd_data_r;
  assign s_rd_data = s_rd_data_r;

endmodule

`default_nettype wire

// ===== rtl/core/hcd_ctrl.sv =====
// Sequencer of the history cursor deque: state registers, operations and expiry scan.
`timescale 1ns / 1ps
`default_nettype none

`include "history_cursor_deque_assert.svh"

module hcd_ctrl #(
  parameter int HISTORY_DEPTH = 16,
  parameter int HANDLE_BITS   = 16,
  parameter int TIME_BITS     = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [hcd_pkg::FUNC_W-1:0]          in_func,
  input  wire logic [HANDLE_BITS-1:0]              in_site_handle,
  input  wire logic [TIME_BITS-1:0]                in_time_now,
  input  wire logic                                cfg_we,
  input  wire logic [hcd_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [hcd_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output hcd_pkg::store_ctl_t                      st_ctl,
  output logic      [$clog2(HISTORY_DEPTH)-1:0]    st_wr_addr,
  output logic      [HANDLE_BITS-1:0]              st_wr_handle,
  output logic      [TIME_BITS-1:0]                st_wr_stamp,
  output logic      [$clog2(HISTORY_DEPTH)-1:0]    st_h_rd_addr,
  output logic      [$clog2(HISTORY_DEPTH)-1:0]    st_s_rd_addr,
  input  wire logic [HANDLE_BITS-1:0]              st_h_rd_data,
  input  wire logic [TIME_BITS-1:0]                st_s_rd_data,
  output logic                                     out_valid,
  output logic      [HANDLE_BITS-1:0]              out_current_handle,
  output logic                                     out_cursor_valid,
  output logic      [hcd_pkg::STATUS_W-1:0]        out_status,
  output logic      [$clog2(HISTORY_DEPTH+1)-1:0]  out_entry_count,
  output logic      [$clog2(HISTORY_DEPTH)-1:0]    out_cursor_position
);

  localparam int SW = $clog2(HISTORY_DEPTH);
  localparam int CW = $clog2(HISTORY_DEPTH + 1);
  localparam int LW = (CW > hcd_pkg::LIMIT_W) ? CW : hcd_pkg::LIMIT_W;
  localparam int EW = (TIME_BITS > hcd_pkg::EXPIRY_W) ? TIME_BITS : hcd_pkg::EXPIRY_W;

  // Slot arithmetic modulo the depth; both operands are below the depth.
  function automatic logic [SW-1:0] slot_add(input logic [SW-1:0] a, input logic [SW-1:0] b);
    logic [SW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (SW+1)'(HISTORY_DEPTH)) begin
      s = s - (SW+1)'(HISTORY_DEPTH);
    end
    return s[SW-1:0];
  endfunction

  hcd_pkg::state_t state_r, state_nxt;
  logic [SW-1:0]   newest_r, newest_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [SW-1:0]   offset_r, offset_nxt;
  logic            cur_valid_r, cur_valid_nxt;
  logic            cmp_vld_r, cmp_vld_nxt;

  logic [hcd_pkg::FUNC_W-1:0]   func_r, func_nxt;
  logic [HANDLE_BITS-1:0]       handle_r, handle_nxt;
  logic [TIME_BITS-1:0]         now_r, now_nxt;
  logic [hcd_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic [CW-1:0]                scan_idx_r, scan_idx_nxt;
  logic [CW-1:0]                hit_cnt_r, hit_cnt_nxt;

  logic [hcd_pkg::LIMIT_W-1:0]  limit_r;
  logic [hcd_pkg::EXPIRY_W-1:0] expiry_r;

  logic [CW-1:0]        lim_eff;
  logic [SW-1:0]        add_slot;
  logic [CW-1:0]        drop_remain;
  logic [CW-1:0]        drop_last;
  logic                 drop_hit;
  logic                 scan_issue;
  logic [TIME_BITS-1:0] age;
  logic                 age_over;

  // Limit as used: zero acts as one, anything above the depth as the depth.
  always_comb begin
    if (limit_r == '0) begin
      lim_eff = CW'(1);
    end else if (LW'(limit_r) > LW'(HISTORY_DEPTH)) begin
      lim_eff = CW'(HISTORY_DEPTH);
    end else begin
      lim_eff = CW'(limit_r);
    end
  end

  assign add_slot = (newest_r == '0) ? SW'(HISTORY_DEPTH - 1) : newest_r - SW'(1);

  // Removal of the oldest entries keeps drop_remain of them; the cursor is hit
  // when it sits at or beyond the new count.
  assign drop_remain = state_r[$clog2(hcd_pkg::S_DROP)] ? count_r - hit_cnt_r : lim_eff;
  assign drop_last   = drop_remain - CW'(1);
  assign drop_hit    = cur_valid_r && (CW'(offset_r) >= drop_remain);

  assign scan_issue = scan_idx_r < count_r;
  assign age        = now_r - st_s_rd_data;
  assign age_over   = EW'(age) > EW'(expiry_r);

  always_comb begin
    state_nxt     = state_r;
    newest_nxt    = newest_r;
    count_nxt     = count_r;
    offset_nxt    = offset_r;
    cur_valid_nxt = cur_valid_r;
    cmp_vld_nxt   = cmp_vld_r;
    func_nxt      = func_r;
    handle_nxt    = handle_r;
    now_nxt       = now_r;
    status_nxt    = status_r;
    scan_idx_nxt  = scan_idx_r;
    hit_cnt_nxt   = hit_cnt_r;

    st_ctl       = '0;
    st_wr_addr   = add_slot;
    st_wr_handle = handle_r;
    st_wr_stamp  = now_r;
    st_h_rd_addr = slot_add(newest_r, offset_r);
    st_s_rd_addr = slot_add(newest_r, scan_idx_r[SW-1:0]);

    unique case (state_r)
      hcd_pkg::S_IDLE: begin
        if (start) begin
          func_nxt   = in_func;
          handle_nxt = in_site_handle;
          now_nxt    = in_time_now;
          status_nxt = hcd_pkg::STATUS_KEPT;
          state_nxt  = hcd_pkg::S_EXEC;
        end
      end
      hcd_pkg::S_EXEC: begin
        state_nxt = hcd_pkg::S_RD;
        unique case (func_r)
          hcd_pkg::FUNC_ADD: begin
            st_ctl.wr_en  = 1'b1;
            newest_nxt    = add_slot;
            count_nxt     = (count_r >= lim_eff) ? count_r : count_r + CW'(1);
            offset_nxt    = '0;
            cur_valid_nxt = 1'b1;
          end
          hcd_pkg::FUNC_BACK: begin
            if (cur_valid_r && (CW'(offset_r) + CW'(1) < count_r)) begin
              offset_nxt = offset_r + SW'(1);
            end
          end
          hcd_pkg::FUNC_FORWARD: begin
            if (cur_valid_r && (offset_r != '0)) begin
              offset_nxt = offset_r - SW'(1);
            end
          end
          hcd_pkg::FUNC_TRUNC: begin
            if (cur_valid_r) begin
              newest_nxt = slot_add(newest_r, offset_r);
              count_nxt  = count_r - CW'(offset_r);
              offset_nxt = '0;
            end else begin
              count_nxt = '0;
            end
          end
          hcd_pkg::FUNC_EXPIRE: begin
            scan_idx_nxt = '0;
            hit_cnt_nxt  = '0;
            cmp_vld_nxt  = 1'b0;
            state_nxt    = hcd_pkg::S_SCAN;
          end
          hcd_pkg::FUNC_TRIM: begin
            if (count_r > lim_eff) begin
              count_nxt = drop_remain;
              if (drop_hit) begin
                offset_nxt = drop_last[SW-1:0];
                status_nxt = hcd_pkg::STATUS_MOVED;
              end
            end
          end
          default: begin
          end
        endcase
      end
      hcd_pkg::S_SCAN: begin
        // One stamp read per cycle; the compare follows in the cycle after each read.
        st_ctl.s_rd_en = scan_issue;
        cmp_vld_nxt    = scan_issue;
        if (scan_issue) begin
          scan_idx_nxt = scan_idx_r + CW'(1);
        end
        if (cmp_vld_r && age_over) begin
          hit_cnt_nxt = hit_cnt_r + CW'(1);
        end
        if (!scan_issue) begin
          state_nxt = hcd_pkg::S_DROP;
        end
      end
      hcd_pkg::S_DROP: begin
        count_nxt = drop_remain;
        if (drop_hit) begin
          if (drop_remain == '0) begin
            cur_valid_nxt = 1'b0;
            offset_nxt    = '0;
            status_nxt    = hcd_pkg::STATUS_EMPTIED;
          end else begin
            offset_nxt = drop_last[SW-1:0];
            status_nxt = hcd_pkg::STATUS_MOVED;
          end
        end
        state_nxt = hcd_pkg::S_RD;
      end
      hcd_pkg::S_RD: begin
        st_ctl.h_rd_en = 1'b1;
        state_nxt      = hcd_pkg::S_RESP;
      end
      hcd_pkg::S_RESP: begin
        state_nxt = hcd_pkg::S_IDLE;
      end
      default: begin
        state_nxt = hcd_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hcd_pkg::S_IDLE;
      newest_r    <= '0;
      count_r     <= '0;
      offset_r    <= '0;
      cur_valid_r <= 1'b0;
      cmp_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      newest_r    <= newest_nxt;
      count_r     <= count_nxt;
      offset_r    <= offset_nxt;
      cur_valid_r <= cur_valid_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    handle_r   <= handle_nxt;
    now_r      <= now_nxt;
    status_r   <= status_nxt;
    scan_idx_r <= scan_idx_nxt;
    hit_cnt_r  <= hit_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r  <= hcd_pkg::LIMIT_RESET;
      expiry_r <= hcd_pkg::EXPIRY_RESET;
    end else if (cfg_we) begin
      if (cfg_index == hcd_pkg::CFG_LIMIT) begin
        limit_r <= cfg_wdata[hcd_pkg::LIMIT_W-1:0];
      end else if (cfg_index == hcd_pkg::CFG_EXPIRY) begin
        expiry_r <= cfg_wdata[hcd_pkg::EXPIRY_W-1:0];
      end
    end
  end

  assign busy                = (state_r != hcd_pkg::S_IDLE);
  assign out_valid           = (state_r == hcd_pkg::S_RESP);
  assign out_current_handle  = cur_valid_r ? st_h_rd_data : '0;
  assign out_cursor_valid    = cur_valid_r;
  assign out_status          = status_r;
  assign out_entry_count     = count_r;
  assign out_cursor_position = cur_valid_r ? offset_r : '0;

  `HCD_ASSERT_HOLDS(a_valid_nonempty, cur_valid_r, count_r != '0, "cursor valid on empty store")
  `HCD_ASSERT_HOLDS(a_cursor_in_range, cur_valid_r, CW'(offset_r) < count_r, "cursor beyond count")
  `HCD_ASSERT_HOLDS(a_count_bound, 1'b1, count_r <= CW'(HISTORY_DEPTH), "count above depth")
  `HCD_ASSERT_NEXT(a_resp_single, state_r == hcd_pkg::S_RESP, state_r == hcd_pkg::S_IDLE, "strobe longer than one cycle")
  `HCD_ASSERT_HOLDS(a_emptied_invalid, (state_r == hcd_pkg::S_RESP) && (status_r == hcd_pkg::STATUS_EMPTIED), !cur_valid_r && (count_r == '0), "emptied store keeps cursor")

endmodule

`default_nettype wire

// ===== rtl/core/history_cursor_deque.sv =====
// Top level of the history cursor deque: sequencer plus entry memories.
// Items are taken one at a time: busy stays high until the result is out, so a new item
// is accepted only after the previous one has completed.
// Expire cost is set by the stamp memory's single read port, one stored entry per cycle.
// Reset (rst_n low, synchronous) empties the store, invalidates the cursor, restores config.
// The result strobe out_valid lasts one cycle and the receiver cannot stall it.
`timescale 1ns / 1ps
`default_nettype none

module history_cursor_deque #(
  parameter int HISTORY_DEPTH = 16,
  parameter int HANDLE_BITS   = 16,
  parameter int TIME_BITS     = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [hcd_pkg::FUNC_W-1:0]         in_func,
  input  wire logic [HANDLE_BITS-1:0]             in_site_handle,
  input  wire logic [TIME_BITS-1:0]               in_time_now,
  input  wire logic                               cfg_we,
  input  wire logic [hcd_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [hcd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output logic                                    out_valid,
  output logic      [HANDLE_BITS-1:0]             out_current_handle,
  output logic                                    out_cursor_valid,
  output logic      [hcd_pkg::STATUS_W-1:0]       out_status,
  output logic      [$clog2(HISTORY_DEPTH+1)-1:0] out_entry_count,
  output logic      [$clog2(HISTORY_DEPTH)-1:0]   out_cursor_position
);

  localparam int SW = $clog2(HISTORY_DEPTH);

  // The store is a circular buffer: the newest entry sits at a moving slot and
  // older entries follow at increasing slots, so no entry is ever moved: add
  // writes the slot below the head, truncate moves the head and trim cuts the
  // count. Handles and stamps live in two registered single-port-read memories.
  hcd_pkg::store_ctl_t    st_ctl;
  logic [SW-1:0]          st_wr_addr;
  logic [HANDLE_BITS-1:0] st_wr_handle;
  logic [TIME_BITS-1:0]   st_wr_stamp;
  logic [SW-1:0]          st_h_rd_addr;
  logic [SW-1:0]          st_s_rd_addr;
  logic [HANDLE_BITS-1:0] st_h_rd_data;
  logic [TIME_BITS-1:0]   st_s_rd_data;

  // The sequencer applies one item at a time. Every item ends with a read of
  // the handle at the cursor, issued after the pointers have settled, so an
  // entry written by add is already in memory when it is read back. Expire
  // walks the stored stamps newest to oldest, one read per cycle, counting
  // entries older than the expiry, then drops that many from the old end.
  hcd_ctrl #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .HANDLE_BITS   (HANDLE_BITS),
    .TIME_BITS     (TIME_BITS)
  ) u_ctrl (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_func             (in_func),
    .in_site_handle      (in_site_handle),
    .in_time_now         (in_time_now),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .st_ctl              (st_ctl),
    .st_wr_addr          (st_wr_addr),
    .st_wr_handle        (st_wr_handle),
    .st_wr_stamp         (st_wr_stamp),
    .st_h_rd_addr        (st_h_rd_addr),
    .st_s_rd_addr        (st_s_rd_addr),
    .st_h_rd_data        (st_h_rd_data),
    .st_s_rd_data        (st_s_rd_data),
    .out_valid           (out_valid),
    .out_current_handle  (out_current_handle),
    .out_cursor_valid    (out_cursor_valid),
    .out_status          (out_status),
    .out_entry_count     (out_entry_count),
    .out_cursor_position (out_cursor_position)
  );

  // Entry memories. Their contents are undefined after reset; stamp reads stay below
  // the entry count, and the handle read is masked to zero when the cursor is invalid.
  hcd_store #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .HANDLE_BITS   (HANDLE_BITS),
    .TIME_BITS     (TIME_BITS)
  ) u_store (
    .clk       (clk),
    .ctl       (st_ctl),
    .wr_addr   (st_wr_addr),
    .wr_handle (st_wr_handle),
    .wr_stamp  (st_wr_stamp),
    .h_rd_addr (st_h_rd_addr),
    .s_rd_addr (st_s_rd_addr),
    .h_rd_data (st_h_rd_data),
    .s_rd_data (st_s_rd_data)
  );

endmodule

`default_nettype wire

// ===== test/hcd_history_checker.sv =====
// Checker that predicts and compares every result of the history cursor deque.
`timescale 1ns / 1ps

module hcd_history_checker #(
  parameter int DEPTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           busy,
  input  logic [hcd_pkg::FUNC_W-1:0]      in_func,
  input  logic [15:0]                    in_site_handle,
  input  logic [31:0]                    in_time_now,
  input  logic                           cfg_we,
  input  logic [hcd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [hcd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                           out_valid,
  input  logic [15:0]                    out_current_handle,
  input  logic                           out_cursor_valid,
  input  logic [hcd_pkg::STATUS_W-1:0]    out_status,
  input  logic [4:0]                     out_entry_count,
  input  logic [3:0]                     out_cursor_position,
  output int                             pending,
  output int                             mismatches
);
  import hcd_pkg::*;

  typedef struct packed {
    logic [15:0]         handle;
    logic                cursor_ok;
    logic [STATUS_W-1:0] status;
    logic [4:0]          count;
    logic [3:0]          position;
  } history_view_t;

  history_view_t expected_views[$];

  logic [15:0]         handle_mem [DEPTH];
  logic [31:0]         stamp_mem [DEPTH];
  logic [3:0]          newest_idx;
  int unsigned         entries;
  int unsigned         cursor_dist;
  bit                  cursor_live;
  logic [LIMIT_W-1:0]  limit_reg;
  logic [EXPIRY_W-1:0] expiry_reg;
  int                  edge_errors;

  // Removes the n oldest entries and tells what became of the cursor.
  function automatic logic [STATUS_W-1:0] drop_oldest_entries(input int unsigned n);
    int unsigned remain;
    bit          hit;
    remain = entries - n;
    hit = cursor_live && (cursor_dist >= remain);
    entries = remain;
    if (!hit) return STATUS_KEPT;
    if (remain == 0) begin
      cursor_live = 1'b0;
      cursor_dist = 0;
      return STATUS_EMPTIED;
    end
    cursor_dist = remain - 1;
    return STATUS_MOVED;
  endfunction

  task automatic step_history(input logic [FUNC_W-1:0] op, input logic [15:0] hnd,
                              input logic [31:0] now, output history_view_t view);
    int unsigned         lim;
    int unsigned         stale;
    logic [3:0]          slot;
    logic [31:0]         age;
    logic [STATUS_W-1:0] st;
    st = STATUS_KEPT;
    if (limit_reg == 0) lim = 1;
    else if (limit_reg > DEPTH) lim = DEPTH;
    else lim = limit_reg;
    if (entries == 0) cursor_live = 1'b0;
    case (op)
      FUNC_ADD: begin
        if (entries >= lim && entries > 0) entries = entries - 1;
        newest_idx = newest_idx - 4'd1;
        handle_mem[newest_idx] = hnd;
        stamp_mem[newest_idx] = now;
        entries = entries + 1;
        cursor_dist = 0;
        cursor_live = 1'b1;
      end
      FUNC_BACK: begin
        if (cursor_live && cursor_dist + 1 < entries) cursor_dist = cursor_dist + 1;
      end
      FUNC_FORWARD: begin
        if (cursor_live && cursor_dist > 0) cursor_dist = cursor_dist - 1;
      end
      FUNC_TRUNC: begin
        if (cursor_live) begin
          newest_idx = newest_idx + cursor_dist[3:0];
          entries = entries - cursor_dist;
          cursor_dist = 0;
        end else begin
          entries = 0;
        end
      end
      FUNC_EXPIRE: begin
        stale = 0;
        for (int unsigned k = 0; k < entries; k++) begin
          slot = newest_idx + k[3:0];
          age = now - stamp_mem[slot];
          if (age > expiry_reg) stale = stale + 1;
        end
        st = drop_oldest_entries(stale);
      end
      FUNC_TRIM: begin
        if (entries > lim) st = drop_oldest_entries(entries - lim);
      end
      default: ;
    endcase
    slot = newest_idx + cursor_dist[3:0];
    view.handle    = cursor_live ? handle_mem[slot] : 16'h0;
    view.cursor_ok = cursor_live;
    view.status    = st;
    view.count     = entries[4:0];
    view.position  = cursor_live ? cursor_dist[3:0] : 4'h0;
  endtask

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", field, want, got);
      edge_errors++;
    end
  endtask

  always @(posedge clk) begin : watch
    history_view_t want;
    int            popped;
    int            pushed;
    popped = 0;
    pushed = 0;
    edge_errors = 0;
    if (!rst_n) begin
      expected_views.delete();
      newest_idx  = 4'h0;
      entries     = 0;
      cursor_dist = 0;
      cursor_live = 1'b0;
      limit_reg   = LIMIT_RESET;
      expiry_reg  = EXPIRY_RESET;
      pending <= 0;
    end else begin
      if (out_valid) begin
        if (expected_views.size() == 0) begin
          $error("result with no item outstanding: handle %0h count %0d",
                 out_current_handle, out_entry_count);
          edge_errors++;
        end else begin
          want = expected_views.pop_front();
          popped = 1;
          check_field("current_handle", want.handle, out_current_handle);
          check_field("cursor_valid", want.cursor_ok, out_cursor_valid);
          check_field("status", want.status, out_status);
          check_field("entry_count", want.count, out_entry_count);
          check_field("cursor_position", want.position, out_cursor_position);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_LIMIT:  limit_reg = cfg_wdata[LIMIT_W-1:0];
          CFG_EXPIRY: expiry_reg = cfg_wdata[EXPIRY_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        step_history(in_func, in_site_handle, in_time_now, want);
        expected_views.push_back(want);
        pushed = 1;
      end
      pending <= pending + pushed - popped;
      mismatches <= mismatches + edge_errors;
    end
  end

endmodule

// ===== test/tb_history_cursor_deque.sv =====
// Testbench top for the history cursor deque: stimulus, register setup and verdict.
`timescale 1ns / 1ps

module tb_history_cursor_deque;
  import hcd_pkg::*;

  localparam int HALF_PERIOD     = 5;
  localparam int RESET_CYCLES    = 6;
  // The limit sits far above the slowest legal run: about 830 items, each at
  // most a full-store expire plus the longest sender gap.
  localparam int CYCLE_LIMIT     = 200000;
  localparam int SETTLE_CYCLES   = 25;
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 100;

  // Code 7 is not assigned an operation; the block treats it as a read.
  localparam logic [FUNC_W-1:0]      FUNC_SPARE = 3'd7;
  // Register index with no register behind it; writes there must do nothing.
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE  = 2'd3;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  logic [FUNC_W-1:0]      in_func = FUNC_READ;
  logic [15:0]            in_site_handle = 16'h0;
  logic [31:0]            in_time_now = 32'h0;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_LIMIT;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
  logic                   out_valid;
  logic [15:0]            out_current_handle;
  logic                   out_cursor_valid;
  logic [STATUS_W-1:0]    out_status;
  logic [4:0]             out_entry_count;
  logic [3:0]             out_cursor_position;

  int pending;
  int mismatches;
  int cycle_count = 0;

  // Time base for the random part. Adds stamp it and expires compare against
  // it, so ages stay small enough for a small expiry to bite.
  logic [31:0] tick = 32'h0;
  int          burst_left = 1;

  always #HALF_PERIOD clk = ~clk;

  history_cursor_deque u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_func             (in_func),
    .in_site_handle      (in_site_handle),
    .in_time_now         (in_time_now),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .out_valid           (out_valid),
    .out_current_handle  (out_current_handle),
    .out_cursor_valid    (out_cursor_valid),
    .out_status          (out_status),
    .out_entry_count     (out_entry_count),
    .out_cursor_position (out_cursor_position)
  );

  hcd_history_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_func             (in_func),
    .in_site_handle      (in_site_handle),
    .in_time_now         (in_time_now),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .out_valid           (out_valid),
    .out_current_handle  (out_current_handle),
    .out_cursor_valid    (out_cursor_valid),
    .out_status          (out_status),
    .out_entry_count     (out_entry_count),
    .out_cursor_position (out_cursor_position),
    .pending             (pending),
    .mismatches          (mismatches)
  );

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Presents one item and returns right after the edge that accepted it.
  // start is left high, so a following call keeps the channel busy with no
  // bubble. Signals read right after an edge still hold their pre-edge values.
  task automatic issue_item(input logic [FUNC_W-1:0] op, input logic [15:0] hnd,
                            input logic [31:0] now);
    start          <= 1'b1;
    in_func        <= op;
    in_site_handle <= hnd;
    in_time_now    <= now;
    do @(posedge clk); while (busy);
  endtask

  // Holds the sender off until every result has come back and the block
  // has gone idle, so that registers can be changed safely.
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0 || busy);
  endtask

  // Writes both registers on consecutive cycles and, if asked, the spare index
  // too. The limit word carries random upper bits, which the register must ignore.
  task automatic program_regs(input logic [LIMIT_W-1:0] lim, input logic [31:0] expiry,
                              input bit poke_spare);
    logic [31:0] word;
    word = $urandom();
    word[LIMIT_W-1:0] = lim;
    cfg_we    <= 1'b1;
    cfg_index <= CFG_LIMIT;
    cfg_wdata <= word;
    @(posedge clk);
    cfg_index <= CFG_EXPIRY;
    cfg_wdata <= expiry;
    @(posedge clk);
    if (poke_spare) begin
      cfg_index <= CFG_SPARE;
      cfg_wdata <= $urandom();
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Sender bursts: after a random number of items the sender may go quiet for
  // a while. Short gaps land inside the sequence of most items, and the long
  // ones reach past a full expire scan. A zero gap keeps the burst going, which
  // gives stretches with no idling at all.
  task automatic maybe_pause();
    int unsigned r;
    int unsigned gap;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 16);
      r = $urandom_range(0, 9);
      if (r < 3) gap = 0;
      else if (r < 8) gap = $urandom_range(1, 4);
      else gap = $urandom_range(5, 24);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Operation mix for the random part. Adds dominate so that the store fills
  // up to the limit and the cursor has room to move; every code, the spare
  // one included, still shows up often.
  function automatic logic [FUNC_W-1:0] pick_op();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 36) return FUNC_ADD;
    else if (r < 50) return FUNC_BACK;
    else if (r < 60) return FUNC_FORWARD;
    else if (r < 67) return FUNC_TRUNC;
    else if (r < 81) return FUNC_EXPIRE;
    else if (r < 89) return FUNC_TRIM;
    else if (r < 95) return FUNC_READ;
    else return FUNC_SPARE;
  endfunction

  initial begin
    logic [LIMIT_W-1:0] lim;
    logic [31:0]        expiry;
    logic [31:0]        now;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, reset configuration (limit 16, expiry one million).
    // Every operation on an empty store first: nothing may move, and truncate
    // with no valid cursor simply leaves the store empty.
    issue_item(FUNC_READ, 16'h0, 32'h0);
    issue_item(FUNC_BACK, 16'h0, 32'h0);
    issue_item(FUNC_FORWARD, 16'h0, 32'h0);
    issue_item(FUNC_TRUNC, 16'h0, 32'h0);
    issue_item(FUNC_EXPIRE, 16'h0, 32'h0);
    issue_item(FUNC_TRIM, 16'h0, 32'h0);
    issue_item(FUNC_SPARE, 16'hFFFF, 32'hFFFF_FFFF);
    // Field extremes, the cursor stopping at the old end, then truncate dropping
    // the newer entry.
    issue_item(FUNC_ADD, 16'h0000, 32'h0000_0000);
    issue_item(FUNC_ADD, 16'hFFFF, 32'hFFFF_FFFF);
    issue_item(FUNC_BACK, 16'h0, 32'h0);
    issue_item(FUNC_BACK, 16'h0, 32'h0);
    issue_item(FUNC_FORWARD, 16'h0, 32'h0);
    issue_item(FUNC_BACK, 16'h0, 32'h0);
    issue_item(FUNC_TRUNC, 16'h0, 32'h0);
    // The last entry is one tick past expiry: the store empties and the cursor
    // goes invalid.
    issue_item(FUNC_EXPIRE, 16'h0, 32'd1000001);
    // Two entries, cursor on the older one, and only that one expires: the
    // cursor is relocated to the oldest survivor. The newer entry sits exactly
    // at the expiry age, which does not count as expired.
    issue_item(FUNC_ADD, 16'h1234, 32'd5);
    issue_item(FUNC_ADD, 16'hABCD, 32'd6);
    issue_item(FUNC_BACK, 16'h0, 32'h0);
    issue_item(FUNC_EXPIRE, 16'h0, 32'd1000006);
    wait_drained();

    // Limit of two with zero expiry: the second and third adds each drop the oldest entry.
    program_regs(5'd2, 32'h0, 1'b0);
    issue_item(FUNC_ADD, 16'h5555, 32'd10);
    issue_item(FUNC_ADD, 16'hAAAA, 32'd11);
    issue_item(FUNC_ADD, 16'h0F0F, 32'd12);
    issue_item(FUNC_BACK, 16'h0, 32'h0);
    wait_drained();

    // Limit written as zero acts as one. The store now holds more than the
    // limit, so an add drops only a single entry, and trim then cuts away the
    // entry under the cursor. With the largest expiry nothing ever expires.
    program_regs(5'd0, 32'hFFFF_FFFF, 1'b1);
    issue_item(FUNC_ADD, 16'hF0F0, 32'd13);
    issue_item(FUNC_BACK, 16'h0, 32'h0);
    issue_item(FUNC_TRIM, 16'h0, 32'h0);
    issue_item(FUNC_EXPIRE, 16'h0, 32'h0);
    wait_drained();

    // Random part: each phase drains the block, picks new register values
    // (the extremes among them) and runs a stream of random items.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin lim = 5'd16; expiry = 32'hFFFF_FFFF; end
        1: begin lim = 5'd0;  expiry = 32'h0; end
        2: begin lim = 5'd31; expiry = $urandom_range(0, 150); end
        3: begin lim = LIMIT_W'($urandom_range(2, 15)); expiry = $urandom_range(0, 150); end
        4: begin lim = 5'd1;  expiry = $urandom_range(0, 150); end
        5: begin lim = LIMIT_W'($urandom_range(17, 30)); expiry = $urandom(); end
        6: begin lim = 5'd16; expiry = $urandom_range(0, 150); end
        default: begin
          lim = LIMIT_W'($urandom_range(0, 31));
          expiry = $urandom_range(0, 150);
        end
      endcase
      // One phase runs its time base across the 32-bit wrap, so that ages
      // are taken modulo the counter width.
      if (p == 3) tick = 32'hFFFF_FF80;
      program_regs(lim, expiry, p == 7);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        tick = tick + $urandom_range(0, 6);
        // Now and then a time far from the base, which makes almost any
        // entry look expired or not expired at all.
        now = ($urandom_range(0, 9) == 0) ? $urandom() : tick;
        issue_item(pick_op(), 16'($urandom_range(0, 65535)), now);
        maybe_pause();
      end
      wait_drained();
    end

    // Everything expected has arrived; give a late or stray result time to
    // show up before the verdict.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
